### hw/rtl/rwb_pkg.sv
// shared types and constants for the rolling window slope block
package rwb_pkg;

   localparam int XW = 16;
   localparam int RW = 32;

   typedef enum logic [1:0] {
      ST_VALID     = 2'd0,
      ST_NOT_FULL  = 2'd1,
      ST_DEGENERATE = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_SHIFT  = 1'b1;

   typedef struct packed {
      logic load;      // capture sample, set up removal
      logic remove;    // subtract oldest pair from sums
      logic add;       // add new pair, write ring
      logic mul_num;   // form numerator/denominator products step
      logic prep_div;  // set up divider
      logic div_step;  // one quotient bit
      logic finish;    // form result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic mul_done;
   } stat_type;

endpackage

### hw/rtl/rolling_window_beta.sv
// top level of the rolling window slope estimator
// Usage: one (x, y) pair per req transaction; req_tdata = {y_sample, x_sample},
// req_tuser = first_of_series. Each transaction yields exactly one rsp transaction
// carrying beta (Q16.16) and status in rsp_tdata / rsp_tuser.
// The result is formed in these steps: remove, add, five multiply steps,
// divider setup, 48 quotient bits from the bit-serial divider, its done
// state, and the result step; the divider sets the pace.
// One item is in work at a time; req_tready is high only while idle, so a
// new transaction is accepted only once the previous result has been formed.
// The result sits in an output register; a stalled receiver holds it and
// the block waits in its last step before overwriting it.
// csr writes: index 0 window_length (also clears the series),
// index 1 negligible_shift. csr_ready is low while an item is in work.
// Reset restores window 60, shift 40, clears fill count and sums;
// the sample ring needs no clearing pass.
// Status: 0 valid, 1 window not full, 2 degenerate variance, 3 saturated.
module rolling_window_beta #(
   parameter int MAX_WINDOW  = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [31:0] req_tdata,   // x_sample[15:0], y_sample[31:16]
   input  logic req_tuser,          // first_of_series
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,   // beta[31:0]
   output logic [1:0] rsp_tuser,    // status[1:0]
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [8:0] csr_data
);
   import rwb_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic rsp_valid_ff;

   // never together with a sample load
   assign csr_ready  = req_tready && !req_tvalid;
   assign rsp_tvalid = rsp_valid_ff;

   rwb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_busy(rsp_valid_ff && !rsp_tready), .stat(stat), .cmd(cmd)
   );

   rwb_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .x_sample(req_tdata[15:0]), .y_sample(req_tdata[31:16]),
      .first_of_series(req_tuser),
      .csr_write(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .beta(rsp_tdata), .status(rsp_tuser)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.finish) else $error("result overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_tready) else $error("accept during divide");
endmodule

### hw/rtl/rwb_ctrl.sv
// controller state machine sequencing the datapath for one sample
module rwb_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic rsp_busy,
   input  rwb_pkg::stat_type stat,
   output rwb_pkg::cmd_type cmd
);
   import rwb_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_ADD, S_MUL, S_PREP, S_DIV, S_DONE}
      state_type;

   state_type state_ff;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.load     = (state_ff == S_IDLE) && req_tvalid;
      cmd.remove   = (state_ff == S_REMOVE);
      cmd.add      = (state_ff == S_ADD);
      cmd.mul_num  = (state_ff == S_MUL);
      cmd.prep_div = (state_ff == S_PREP);
      // no step once the count has run out
      cmd.div_step = (state_ff == S_DIV) && !stat.div_done;
      cmd.finish   = (state_ff == S_DONE) && !rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:   if (req_tvalid) state_ff <= S_REMOVE;
            S_REMOVE: state_ff <= S_ADD;
            S_ADD:    state_ff <= S_MUL;
            S_MUL:    if (stat.mul_done) state_ff <= S_PREP;
            S_PREP:   state_ff <= S_DIV;
            S_DIV:    if (stat.div_done) state_ff <= S_DONE;
            S_DONE:   if (!rsp_busy) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.div_step) else $error("divide while idle");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.remove, cmd.add, cmd.mul_num, cmd.prep_div, cmd.div_step}))
      else $error("overlapping commands");
   a_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.remove) else $error("load not followed by remove");
endmodule

### hw/rtl/rwb_datapath.sv
// sample ring, running sums, product steps and bit-serial divider
module rwb_datapath #(
   parameter int MAX_WINDOW  = 256
) (
   input  logic clock,
   input  logic reset,
   input  rwb_pkg::cmd_type cmd,
   output rwb_pkg::stat_type stat,
   input  logic [rwb_pkg::XW-1:0] x_sample,
   input  logic [rwb_pkg::XW-1:0] y_sample,
   input  logic first_of_series,
   input  logic csr_write,
   input  logic csr_index,
   input  logic [8:0] csr_data,
   output logic [31:0] beta,
   output logic [1:0] status
);
   import rwb_pkg::*;

   localparam int AW  = $clog2(MAX_WINDOW);
   localparam int CW  = $clog2(MAX_WINDOW + 1);
   localparam int SW  = XW + CW;                   // linear sums
   localparam int PW  = 2 * XW + CW;               // product sums
   localparam int NW  = PW + CW + 2;               // numerator/denominator
   localparam int QB  = 48;                        // quotient bits computed
   localparam int DW  = NW + QB;

   // ring of 2**AW entries: indexing wraps naturally for any window
   logic signed [XW-1:0] x_mem [2**AW];
   logic signed [XW-1:0] y_mem [2**AW];

   logic [8:0] win_ff;
   logic [5:0] shift_ff;
   logic [AW-1:0] wp_ff;
   logic [CW-1:0] fill_ff;
   logic signed [SW-1:0] sx_ff, sy_ff;
   logic signed [PW-1:0] sxy_ff, sxx_ff;
   logic signed [XW-1:0] x_ff, y_ff, xo_ff, yo_ff;
   logic full_ff;
   logic [CW-1:0] w_eff;

   // product sequencer
   logic [2:0] mstep_ff;
   logic signed [NW-1:0] mprod_ff, num_ff, den_ff, scale_ff;

   // divider
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] dvs_ff;
   logic [QB-1:0] quo_ff;
   logic [5:0] dcnt_ff;
   logic neg_ff, degen_ff, ovf_ff;

   always_comb begin
      if (win_ff < 9'd2) w_eff = CW'(2);
      else if (32'(win_ff) > MAX_WINDOW) w_eff = CW'(MAX_WINDOW);
      else w_eff = CW'(win_ff);
   end

   logic [AW-1:0] old_idx;
   assign old_idx = AW'(wp_ff - AW'(w_eff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff  <= x_sample;
         y_ff  <= y_sample;
      end
      xo_ff <= x_mem[old_idx];
      yo_ff <= y_mem[old_idx];
      if (cmd.add) begin
         x_mem[wp_ff] <= x_ff;
         y_mem[wp_ff] <= y_ff;
      end
   end

   // multiplier operand select per step
   logic signed [SW-1:0] ma;
   logic signed [PW-1:0] mb;
   always_comb begin
      ma = '0; mb = '0;
      case (mstep_ff)
         3'd0: begin ma = SW'(signed'({1'b0, w_eff})); mb = sxx_ff; end
         3'd1: begin ma = sx_ff; mb = PW'(sx_ff); end
         3'd2: begin ma = SW'(signed'({1'b0, w_eff})); mb = sxy_ff; end
         3'd3: begin ma = sx_ff; mb = PW'(sy_ff); end
         default: ;
      endcase
   end

   assign stat.mul_done = (mstep_ff == 3'd4);
   assign stat.div_done = (dcnt_ff == 6'd0);

   logic [NW-1:0] dmag_num;
   assign dmag_num = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
   logic [DW-1:0] trial;
   assign trial = {rem_ff[DW-2:0], 1'b0};
   logic [NW:0] sub;
   assign sub = {1'b0, trial[DW-1:DW-NW]} - {1'b0, dvs_ff};
   logic [NW-1:0] thr;
   assign thr = NW'(scale_ff >>> shift_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= 9'd60; shift_ff <= 6'd40; wp_ff <= '0; fill_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; sxy_ff <= '0; sxx_ff <= '0;
         mstep_ff <= '0; dcnt_ff <= '0; full_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_WINDOW) begin
               win_ff <= csr_data;
               fill_ff <= '0; sx_ff <= '0; sy_ff <= '0; sxy_ff <= '0; sxx_ff <= '0;
            end else shift_ff <= csr_data[5:0];
         end
         if (cmd.load && first_of_series) begin
            fill_ff <= '0; sx_ff <= '0; sy_ff <= '0; sxy_ff <= '0; sxx_ff <= '0;
         end
         if (cmd.remove) begin
            if (fill_ff >= w_eff) begin
               sx_ff  <= sx_ff - SW'(xo_ff);
               sy_ff  <= sy_ff - SW'(yo_ff);
               sxy_ff <= sxy_ff - PW'(xo_ff * yo_ff);
               sxx_ff <= sxx_ff - PW'(xo_ff * xo_ff);
               fill_ff <= w_eff;
            end else fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.add) begin
            sx_ff  <= sx_ff + SW'(x_ff);
            sy_ff  <= sy_ff + SW'(y_ff);
            sxy_ff <= sxy_ff + PW'(x_ff * y_ff);
            sxx_ff <= sxx_ff + PW'(x_ff * x_ff);
            wp_ff  <= wp_ff + 1'b1;
            full_ff <= (fill_ff >= w_eff);
            mstep_ff <= '0;
         end
         if (cmd.mul_num) begin
            mprod_ff <= NW'(ma * mb);
            case (mstep_ff)
               3'd1: scale_ff <= mprod_ff;
               3'd2: den_ff <= scale_ff - mprod_ff;
               3'd3: num_ff <= mprod_ff;
               3'd4: num_ff <= num_ff - mprod_ff;
               default: ;
            endcase
            mstep_ff <= mstep_ff + 1'b1;
         end
         if (cmd.prep_div) begin
            neg_ff   <= num_ff[NW-1];
            degen_ff <= den_ff[NW-1] || (den_ff == '0) || (NW'(den_ff) <= thr);
            // quotient would not fit the QB bits
            ovf_ff   <= (dmag_num >> 32) >= $unsigned(den_ff);
            rem_ff   <= DW'(dmag_num) << 16;
            dvs_ff   <= NW'(den_ff);
            quo_ff   <= '0;
            dcnt_ff  <= 6'(QB);
         end
         if (cmd.div_step) begin
            if (!sub[NW]) rem_ff <= {sub[NW-1:0], trial[DW-NW-1:0]};
            else rem_ff <= trial;
            quo_ff <= {quo_ff[QB-2:0], !sub[NW]};
            dcnt_ff <= dcnt_ff - 1'b1;
         end
      end
   end

   // result: numerator is pre-shifted left by 16 inside rem (low QB bits of quotient)
   logic [QB-1:0] qmag;
   assign qmag = quo_ff;
   logic over;
   assign over = ovf_ff ||
                 (neg_ff ? (qmag > QB'(33'h80000000)) : (qmag > QB'(32'h7FFFFFFF)));

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (!full_ff) begin
            beta <= '0; status <= ST_NOT_FULL;
         end else if (degen_ff) begin
            beta <= '0; status <= ST_DEGENERATE;
         end else if (over) begin
            beta <= neg_ff ? 32'h80000000 : 32'h7FFFFFFF; status <= ST_SATURATED;
         end else begin
            beta <= neg_ff ? 32'(-qmag) : qmag[31:0]; status <= ST_VALID;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_WINDOW)) else $error("fill past window");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> dcnt_ff != 6'd0) else $error("divider overrun");
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      cmd.prep_div |-> $past(stat.mul_done)) else $error("divide before products");
endmodule

### verif/tb_top.sv
// self-checking testbench for the rolling window slope estimator
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rwb_pkg::*;

   localparam int WIN_MAX = 256;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic signed [31:0] beta;
      status_type status;
   } slope_result_type;

   class slope_board;
      int unsigned win_len;
      int unsigned neg_shift;
      longint x_ring[WIN_MAX];
      longint y_ring[WIN_MAX];
      int unsigned wr_ptr;
      int unsigned filled;
      longint sx, sy, sxy, sxx;
      slope_result_type pending[$];
      int errors;
      int status_seen[4];

      function new();
         win_len = 60;
         neg_shift = 40;
         wr_ptr = 0;
         errors = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         filled = 0;
         sx = 0;
         sy = 0;
         sxy = 0;
         sxx = 0;
      endfunction

      function void write_reg(logic idx, logic [8:0] val);
         if (idx == CSR_WINDOW) begin
            win_len = val;
            clear_sums();
         end else begin
            neg_shift = val[5:0];
         end
      endfunction

      // note an accepted sample pair and queue the slope it must produce
      function void note_sample(logic signed [15:0] xs, logic signed [15:0] ys, logic first);
         int unsigned w, old;
         longint xv, yv, scale, den, num;
         longint unsigned mag_a, d, q, r, lim, mag;
         logic neg;
         slope_result_type res;
         xv = xs;
         yv = ys;
         w = (win_len < 2) ? 2 : ((win_len > WIN_MAX) ? WIN_MAX : win_len);
         res.beta = '0;
         if (first)
            clear_sums();
         if (filled >= w) begin
            old = (wr_ptr + WIN_MAX - w) % WIN_MAX;
            sx -= x_ring[old];
            sy -= y_ring[old];
            sxy -= x_ring[old] * y_ring[old];
            sxx -= x_ring[old] * x_ring[old];
            filled = w;
         end else begin
            filled++;
         end
         x_ring[wr_ptr] = xv;
         y_ring[wr_ptr] = yv;
         sx += xv;
         sy += yv;
         sxy += xv * yv;
         sxx += xv * xv;
         wr_ptr = (wr_ptr + 1) % WIN_MAX;
         if (filled < w) begin
            res.status = ST_NOT_FULL;
         end else begin
            scale = longint'(w) * sxx;
            den = scale - sx * sx;
            num = longint'(w) * sxy - sx * sy;
            // scale is never negative, so the shift is a plain magnitude shift
            if (den <= 0 || den <= (scale >> neg_shift)) begin
               res.status = ST_DEGENERATE;
            end else begin
               neg = num < 0;
               mag_a = neg ? -num : num;
               d = den;
               q = mag_a / d;
               r = mag_a % d;
               lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
               mag = (q > 64'h8000) ? lim + 1 : (q << 16) + (r << 16) / d;
               if (mag > lim) begin
                  res.status = ST_SATURATED;
                  res.beta = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  res.status = ST_VALID;
                  res.beta = neg ? -mag[31:0] : mag[31:0];
               end
            end
         end
         pending.push_back(res);
      endfunction

      function void check_slope(logic [31:0] beta, logic [1:0] st);
         slope_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beta=%h status=%0d", $time, beta, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         status_seen[st]++;
         if (beta !== e.beta)
            begin
               $display("%0t: beta mismatch expected %h actual %h", $time, e.beta, beta);
               errors++;
            end
         if (st !== e.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid, csr_ready, csr_index;
   logic [8:0] csr_data;

   slope_board board;
   int idle_cycles;
   int samples_sent;
   bit rsp_stall_on;

   rolling_window_beta DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: stalls at random cycles while stalling is on, never otherwise
   always @(negedge clock) begin
      if (!rsp_stall_on)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_slope(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
               (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL rolling_window_beta");
            $finish;
         end
      end
   end

   task automatic send_sample(logic signed [15:0] xs, logic signed [15:0] ys, logic first);
      req_tdata <= {ys, xs};
      req_tuser <= first;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_sample(xs, ys, first);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [8:0] val);
      drain();
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // random series: the mode picks independent, correlated, near-constant y or two-valued x pairs
   task automatic run_series(int n, int mode, int first_odds);
      int burst;
      logic signed [15:0] xs, ys;
      burst = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         xs = 16'($urandom);
         case (mode)
            0: ys = 16'($urandom);
            1: ys = (xs >>> 1) + $signed(16'($urandom_range(0, 15)) - 16'sd8);
            2: ys = 16'sd100 + $signed(16'($urandom_range(0, 3)));
            default: begin
               xs = 16'($urandom_range(0, 1));
               ys = 16'($urandom);
            end
         endcase
         send_sample(xs, ys, (i == 0) ? 1'b1 : ($urandom_range(0, first_odds) == 0));
         if (--burst == 0) begin
            send_gap();
            burst = $urandom_range(1, 12);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      rsp_stall_on = 0;
      csr_valid = 0;
      csr_index = CSR_WINDOW;
      csr_data = '0;
      idle_cycles = 0;
      samples_sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: smallest window, extremes, degenerate and saturating slopes
      write_reg(CSR_WINDOW, 9'd0);
      send_sample(16'sh8000, 16'sh7FFF, 1'b1);
      send_sample(16'sh7FFF, 16'sh8000, 1'b0);
      send_sample(16'sh0005, 16'sh0005, 1'b0);
      send_sample(16'sh0005, 16'sh0006, 1'b0);
      send_sample(16'sh0000, 16'sh7FFF, 1'b0);
      send_sample(16'sh0001, 16'sh8000, 1'b0);
      send_sample(16'shFFFF, 16'shFFFF, 1'b1);
      send_sample(16'sh0001, 16'sh0001, 1'b0);
      send_sample(16'sh0002, 16'sh0003, 1'b0);
      req_tvalid <= 1'b0;
      write_reg(CSR_SHIFT, 9'd0);
      send_sample(16'sh0001, 16'sh0001, 1'b0);
      send_sample(16'sh0002, 16'sh7FFF, 1'b0);
      req_tvalid <= 1'b0;
      write_reg(CSR_SHIFT, 9'd63);
      write_reg(CSR_WINDOW, 9'd511);
      run_series(20, 1, 60);
      write_reg(CSR_WINDOW, 9'd3);
      send_sample(16'sh1234, 16'shFEDC, 1'b0);
      send_sample(16'sh1234, 16'sh0000, 1'b0);
      send_sample(16'sh1234, 16'sh7000, 1'b0);
      req_tvalid <= 1'b0;

      // random phases over several settings; the long one fills and wraps the ring
      rsp_stall_on = 1;
      write_reg(CSR_WINDOW, 9'd256);
      write_reg(CSR_SHIFT, 9'd10);
      run_series(300, 1, 2000);
      rsp_stall_on = 0;
      write_reg(CSR_WINDOW, 9'd2);
      run_series(20, 3, 60);
      rsp_stall_on = 1;
      write_reg(CSR_WINDOW, 9'd1);
      write_reg(CSR_SHIFT, 9'd4);
      run_series(20, 2, 60);
      write_reg(CSR_WINDOW, 9'd7);
      write_reg(CSR_SHIFT, 9'd30);
      run_series(30, 0, 60);
      drain();

      $display("sent %0d samples; status counts valid %0d not-full %0d degenerate %0d sat %0d",
               samples_sent, board.status_seen[0], board.status_seen[1],
               board.status_seen[2], board.status_seen[3]);
      if (board.errors == 0)
         $display("PASS rolling_window_beta");
      else
         $display("FAIL rolling_window_beta");
      $finish;
   end
endmodule
